>>> rtl/vrra_pkg.sv
// Package for the variable record ring allocator.
// Item structs, field widths, default sizes, action codes and the controller/datapath link.
// No dependencies.
package vrra_pkg;

    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_RECORDS_DEF  = 64;
    localparam int OFFSET_BITS_DEF  = 16;

    localparam int FIELD_W = 16;
    localparam int TAG_W   = 8;

    localparam logic [FIELD_W-1:0] BUFFER_BYTES_RST = 16'd4096;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] payload_bytes;
        logic [TAG_W-1:0]   handler_tag;
    } req_t;

    typedef struct packed {
        logic               success;
        logic [FIELD_W-1:0] payload_offset;
        logic [FIELD_W-1:0] record_bytes;
        logic [TAG_W-1:0]   record_tag;
        logic [FIELD_W-1:0] head_offset;
        logic [FIELD_W-1:0] tail_offset;
        logic               occupied;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch item, read record FIFO head
        logic exec;   // evaluate item, update positions, write result
        logic fix;    // clear next offset of the record before a wrapped one
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic wrap;   // valid during exec: add wrapped to offset 0
    } dp_status_t;

endpackage

>>> rtl/variable_record_ring_allocator_unit.sv
// Top level of the variable record ring allocator.
// Joins vrra_ctrl and vrra_dp; depends on vrra_pkg.
//
// Usage:
//   request/start/busy: an item (add or take) is accepted on a rising edge with
//     start high and busy low. busy stays high while the item is in work.
//   result/done: one result per item, on result for the single cycle that done
//     is high. The receiver must take it then; there is no back-pressure.
//   cfg_wr_en/cfg_wr_data: writes the ring size in bytes; write only while idle.
// Timing:
//   Accept edge: item latched, record FIFO head read from memory.
//   Exec state: space check or take, positions updated, result registered.
//   done is high in the cycle after the exec state; busy is low in that same cycle
//   unless the add wraps, so a new item can then be accepted.
//   An add that wraps to offset 0 goes on to a fix state that clears the next offset
//   of the previous record (single write port of the next-offset memory).
// Reset: positions zero, queue empty, ring size 4096 bytes. The record FIFO
//   memories are not cleared; entries are only read after being written.
module variable_record_ring_allocator_unit
    import vrra_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               request,
    output logic               done,
    output rsp_t               result,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    vrra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vrra_dp #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_RECORDS  (MAX_RECORDS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .request     (request),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .result      (result)
    );

`ifndef SYNTH
    // an accepted item raises busy, then yields its result once the exec state has registered done
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result not delivered on time");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // an empty queue always reports both positions at zero
    a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.occupied) |-> (result.head_offset == '0 && result.tail_offset == '0))
        else $error("empty queue with nonzero positions");
`endif

endmodule

>>> rtl/vrra_ctrl.sv
// Controller state machine for the ring allocator.
// Sequences load, exec and the optional wrap fixup; depends on vrra_pkg.
module vrra_ctrl
    import vrra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIX
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = status.wrap ? ST_FIX : ST_IDLE;
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
        done_next = (state_reg == ST_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.load = (state_reg == ST_IDLE) && start;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign cmd.fix  = (state_reg == ST_FIX);
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

>>> rtl/vrra_dp.sv
// Datapath for the ring allocator: positions, size register, record FIFO memories,
// space check and result register. Depends on vrra_pkg.
module vrra_dp
    import vrra_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  req_t               request,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    output dp_status_t         status,
    output rsp_t               result
);

    localparam int POS_W   = OFFSET_BITS;
    localparam int IDX_W   = $clog2(MAX_RECORDS);
    localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
    localparam int CHUNK_W = $clog2(HEADER_BYTES + (1 << FIELD_W));
    localparam int SUM_W   = ((POS_W > CHUNK_W) ? POS_W : CHUNK_W) + 1;

    // record FIFO stores
    logic [POS_W-1:0]   next_mem [MAX_RECORDS];
    logic [FIELD_W-1:0] size_mem [MAX_RECORDS];
    logic [TAG_W-1:0]   tag_mem  [MAX_RECORDS];

    logic [FIELD_W-1:0] buffer_reg;
    logic [POS_W-1:0]   head_reg, head_next;
    logic [POS_W-1:0]   tail_reg, tail_next;
    logic               nonempty_reg, nonempty_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   fix_idx_reg, fix_idx_next;

    // latched item and head record
    logic               act_reg;
    logic [FIELD_W-1:0] psize_reg;
    logic [TAG_W-1:0]   ptag_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [POS_W-1:0]   rd_next_reg;
    logic [FIELD_W-1:0] rd_size_reg;
    logic [TAG_W-1:0]   rd_tag_reg;

    rsp_t               rsp_reg, rsp_next;

    logic               take_ok, room, fits, wrap_ok, add_ok, wrap;
    logic [SUM_W-1:0]   head_ext, tail_ext, chunk_ext, buf_ext;
    logic [SUM_W-1:0]   limit_ext, end_ext, new_end, start_ext, poff_ext;
    logic [POS_W-1:0]   start_pos, add_next;
    logic [SUM_W-1:0]   head_out_ext, tail_out_ext;

    logic               next_we;
    logic [IDX_W-1:0]   next_waddr;
    logic [POS_W-1:0]   next_wdata;
    logic               rec_we;

    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == IDX_W'(MAX_RECORDS - 1)) ? '0 : i + 1'b1;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == '0) ? IDX_W'(MAX_RECORDS - 1) : i - 1'b1;
        return r;
    endfunction

    assign head_ext  = SUM_W'(head_reg);
    assign tail_ext  = SUM_W'(tail_reg);
    assign chunk_ext = SUM_W'(chunk_reg);
    assign buf_ext   = SUM_W'(buffer_reg);

    // take check and space check for an add
    assign take_ok   = nonempty_reg && (count_reg != '0);
    assign room      = (count_reg < CNT_W'(MAX_RECORDS));
    assign limit_ext = (!nonempty_reg || (head_reg < tail_reg)) ? buf_ext : head_ext;
    assign end_ext   = tail_ext + chunk_ext;
    assign fits      = (end_ext <= limit_ext);
    assign wrap_ok   = !fits && nonempty_reg && (tail_reg > head_reg)
                       && (head_reg != '0) && (chunk_ext < head_ext);
    assign add_ok    = room && (fits || wrap_ok);
    assign wrap      = room && wrap_ok;
    assign start_pos = wrap ? '0 : tail_reg;
    assign start_ext = SUM_W'(start_pos);
    assign new_end   = start_ext + chunk_ext;
    assign add_next  = new_end[POS_W-1:0];

    assign status.wrap = cmd.exec && (act_reg == ACT_ADD) && wrap;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        count_next    = count_reg;
        fix_idx_next  = fix_idx_reg;
        rec_we        = 1'b0;
        next_we       = 1'b0;
        next_waddr    = wr_idx_reg;
        next_wdata    = add_next;
        poff_ext      = '0;
        rsp_next      = '0;

        if (cmd.exec)
        begin
            if (act_reg == ACT_ADD)
            begin
                if (add_ok)
                begin
                    poff_ext      = start_ext + SUM_W'(HEADER_BYTES);
                    rec_we        = 1'b1;
                    next_we       = 1'b1;
                    tail_next     = add_next;
                    nonempty_next = 1'b1;
                    wr_idx_next   = slot_after(wr_idx_reg);
                    count_next    = count_reg + 1'b1;
                    fix_idx_next  = slot_before(wr_idx_reg);
                    rsp_next.success      = 1'b1;
                    rsp_next.record_bytes = psize_reg;
                    rsp_next.record_tag   = ptag_reg;
                end
            end
            else if (take_ok)
            begin
                poff_ext    = head_ext + SUM_W'(HEADER_BYTES);
                head_next   = rd_next_reg;
                rd_idx_next = slot_after(rd_idx_reg);
                count_next  = count_reg - 1'b1;
                rsp_next.success      = 1'b1;
                rsp_next.record_bytes = rd_size_reg;
                rsp_next.record_tag   = rd_tag_reg;
                // queue drained
                if (rd_next_reg == tail_reg)
                begin
                    head_next     = '0;
                    tail_next     = '0;
                    nonempty_next = 1'b0;
                end
            end
        end
        else if (cmd.fix)
        begin
            next_we    = 1'b1;
            next_waddr = fix_idx_reg;
            next_wdata = '0;
        end

        head_out_ext            = SUM_W'(head_next);
        tail_out_ext            = SUM_W'(tail_next);
        rsp_next.payload_offset = poff_ext[FIELD_W-1:0];
        rsp_next.head_offset    = head_out_ext[FIELD_W-1:0];
        rsp_next.tail_offset    = tail_out_ext[FIELD_W-1:0];
        rsp_next.occupied       = nonempty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_reg   <= BUFFER_BYTES_RST;
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            count_reg    <= '0;
            fix_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                buffer_reg <= cfg_wr_data;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            count_reg    <= count_next;
            fix_idx_reg  <= fix_idx_next;
        end
    end

    // item latch and registered FIFO read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= request.action;
            psize_reg   <= request.payload_bytes;
            ptag_reg    <= request.handler_tag;
            chunk_reg   <= CHUNK_W'(HEADER_BYTES) + CHUNK_W'(request.payload_bytes);
            rd_next_reg <= next_mem[rd_idx_reg];
            rd_size_reg <= size_mem[rd_idx_reg];
            rd_tag_reg  <= tag_mem[rd_idx_reg];
        end
        if (cmd.exec)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (rec_we)
        begin
            size_mem[wr_idx_reg] <= psize_reg;
            tag_mem[wr_idx_reg]  <= ptag_reg;
        end
    end

    assign result = rsp_reg;

endmodule

>>> test/variable_record_ring_allocator_unit_tb.sv
// Testbench for variable_record_ring_allocator_unit: directed and random add/take traffic,
// each result checked against an in-bench model of the ring and its record FIFO.
// Depends on vrra_pkg and the top level only.
module variable_record_ring_allocator_unit_tb;
    import vrra_pkg::*;

    localparam int HDR         = HEADER_BYTES_DEF;
    localparam int SLOTS       = MAX_RECORDS_DEF;
    localparam int STALL_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    req_t               request;
    logic               done;
    rsp_t               result;
    logic               cfg_wr_en;
    logic [FIELD_W-1:0] cfg_wr_data;

    variable_record_ring_allocator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Model of the ring: positions, record FIFO and ring size
    int          ring_size = int'(BUFFER_BYTES_RST);
    int          ring_head = 0;
    int          ring_tail = 0;
    bit          ring_holding = 0;
    int          slot_next [SLOTS];
    int          slot_size [SLOTS];
    int          slot_tag  [SLOTS];
    int          rd_slot = 0;
    int          wr_slot = 0;
    int          slot_count = 0;

    rsp_t        owed_results [$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          adds_placed = 0;
    int          takes_done = 0;
    int          wraps_seen = 0;
    int          ops_refused = 0;
    int          stall_cycles = 0;

    function automatic rsp_t predict_ring_step(req_t it);
        rsp_t r;
        int   chunk;
        int   lim;
        bit   fits;
        r = '0;
        if (it.action == ACT_ADD)
        begin
            chunk = HDR + int'(it.payload_bytes);
            if (slot_count < SLOTS)
            begin
                lim  = (!ring_holding || ring_head < ring_tail) ? ring_size : ring_head;
                fits = (ring_tail + chunk) <= lim;
                if (!fits && ring_holding && ring_tail > ring_head && ring_head > 0 &&
                    chunk < ring_head)
                begin
                    slot_next[(wr_slot == 0) ? SLOTS - 1 : wr_slot - 1] = 0;
                    ring_tail = 0;
                    fits = 1;
                    wraps_seen++;
                end
                if (fits)
                begin
                    r.success        = 1'b1;
                    r.payload_offset = 16'(ring_tail + HDR);
                    r.record_bytes   = it.payload_bytes;
                    r.record_tag     = it.handler_tag;
                    slot_next[wr_slot] = (ring_tail + chunk) & 16'hFFFF;
                    slot_size[wr_slot] = int'(it.payload_bytes);
                    slot_tag[wr_slot]  = int'(it.handler_tag);
                    ring_tail    = slot_next[wr_slot];
                    wr_slot      = (wr_slot + 1) % SLOTS;
                    slot_count++;
                    ring_holding = 1;
                    adds_placed++;
                end
            end
        end
        else if (ring_holding && slot_count > 0)
        begin
            r.success        = 1'b1;
            r.payload_offset = 16'(ring_head + HDR);
            r.record_bytes   = 16'(slot_size[rd_slot]);
            r.record_tag     = 8'(slot_tag[rd_slot]);
            ring_head = slot_next[rd_slot];
            rd_slot   = (rd_slot + 1) % SLOTS;
            slot_count--;
            takes_done++;
            if (ring_head == ring_tail)
            begin
                ring_head    = 0;
                ring_tail    = 0;
                ring_holding = 0;
            end
        end
        if (!r.success)
            ops_refused++;
        r.head_offset = 16'(ring_head);
        r.tail_offset = 16'(ring_tail);
        r.occupied    = ring_holding;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Result checker: a result is on the ports for exactly one cycle
    always @(posedge clk)
    begin
        rsp_t want;
        if (done === 1'b1)
        begin
            results_seen++;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, result);
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("success", 16'(want.success), 16'(result.success));
                check_field("payload_offset", want.payload_offset, result.payload_offset);
                check_field("record_bytes", want.record_bytes, result.record_bytes);
                check_field("record_tag", 16'(want.record_tag), 16'(result.record_tag));
                check_field("head_offset", want.head_offset, result.head_offset);
                check_field("tail_offset", want.tail_offset, result.tail_offset);
                check_field("occupied", 16'(want.occupied), 16'(result.occupied));
            end
        end
    end

    // Watchdog on cycles without any accepted item, result or register write
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1 || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, owed_results.size());
            $display("variable_record_ring_allocator_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [15:0] bytes, logic [7:0] tag);
        req_t it;
        it.action        = act;
        it.payload_bytes = bytes;
        it.handler_tag   = tag;
        @(negedge clk);
        start   <= 1'b1;
        request <= it;
        do
            @(posedge clk);
        while (busy);
        owed_results.push_back(predict_ring_step(it));
        items_sent++;
    endtask

    task automatic idle_gap(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ring_size(logic [15:0] bytes);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(posedge clk);
        ring_size = int'(bytes);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic take_all();
        while (ring_holding)
            send_item(ACT_TAKE, 16'($urandom), 8'($urandom));
    endtask

    // Reset size: take on empty, oversize add, exact fit, then a header-only add that does not fit and a take
    task automatic test_empty_and_exact_fit();
        send_item(ACT_TAKE, 16'hFFFF, 8'hFF);
        send_item(ACT_ADD, 16'hFFFF, 8'hA5);
        send_item(ACT_ADD, 16'(BUFFER_BYTES_RST - HDR), 8'hFF);
        send_item(ACT_ADD, 16'd0, 8'h00);
        send_item(ACT_TAKE, 16'd0, 8'h00);
    endtask

    // Wrap to offset 0, tail meeting head, then a full ring refusing an add
    task automatic test_wrap_around();
        write_ring_size(16'd200);
        send_item(ACT_ADD, 16'd50, 8'h11);
        send_item(ACT_ADD, 16'd50, 8'h22);
        send_item(ACT_TAKE, 16'd0, 8'h00);
        send_item(ACT_ADD, 16'd10, 8'h33);
        send_item(ACT_ADD, 16'd26, 8'h44);
        send_item(ACT_ADD, 16'd0, 8'h55);
        send_item(ACT_ADD, 16'd0, 8'h66);
        take_all();
        send_item(ACT_TAKE, 16'd0, 8'h00);
    endtask

    // Record FIFO full, then a size change while records are held
    task automatic test_record_fifo_full();
        write_ring_size(16'hFFFF);
        repeat (SLOTS) send_item(ACT_ADD, 16'd0, 8'($urandom));
        send_item(ACT_ADD, 16'd0, 8'h77);
        send_item(ACT_TAKE, 16'd0, 8'h00);
        write_ring_size(16'd100);
        send_item(ACT_ADD, 16'd0, 8'h88);
        take_all();
    endtask

    task automatic test_size_extremes();
        write_ring_size(16'd1);
        send_item(ACT_ADD, 16'd0, 8'h01);
        send_item(ACT_TAKE, 16'd0, 8'h00);
        write_ring_size(16'hFFFF);
        send_item(ACT_ADD, 16'hFFFF, 8'hFE);
        send_item(ACT_ADD, 16'(16'hFFFF - HDR), 8'h7F);
        send_item(ACT_ADD, 16'd0, 8'h80);
        send_item(ACT_TAKE, 16'd0, 8'h00);
    endtask

    // Payload sizes aimed at the boundaries the space check cares about
    function automatic logic [15:0] pick_payload(int small_max);
        int roll;
        int room;
        roll = $urandom_range(99);
        room = ((!ring_holding || ring_head < ring_tail) ? ring_size : ring_head)
               - ring_tail - HDR;
        if (roll < 8)
            return 16'($urandom);
        if (roll < 20 && room >= 0 && room <= 16'hFFFF)
            return 16'(room + (($urandom_range(3) == 0) ? 1 : 0));
        if (roll < 28 && ring_head > HDR)
            return 16'(ring_head - HDR - $urandom_range(1));
        return 16'($urandom_range(small_max));
    endfunction

    task automatic test_random_traffic(int count, int idle_pct, int take_pct, int small_max,
                                       bit mid_drain);
        for (int n = 0; n < count; n++)
        begin
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                idle_gap($urandom_range(1, 4));
            if (mid_drain && n == count / 2)
                wait_drained();
            if ($urandom_range(99) < take_pct)
                send_item(ACT_TAKE, 16'($urandom), 8'($urandom));
            else
                send_item(ACT_ADD, pick_payload(small_max), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_exact_fit();
        test_wrap_around();
        test_record_fifo_full();
        test_size_extremes();

        write_ring_size(16'd4096);
        test_random_traffic(300, 26, 40, 600, 0);
        write_ring_size(16'd256);
        test_random_traffic(300, 50, 45, 90, 1);
        write_ring_size(16'hFFFF);
        test_random_traffic(350, 0, 22, 300, 0);
        write_ring_size(16'($urandom_range(100, 2000)));
        test_random_traffic(300, 0, 45, 200, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("%0d items, %0d results: %0d records placed, %0d taken, %0d wraps, %0d refused",
                 items_sent, results_seen, adds_placed, takes_done, wraps_seen, ops_refused);
        $display("ring sizes from 1 to 65535 bytes, record FIFO full and size changed while held");
        if (errors == 0 && owed_results.size() == 0)
            $display("variable_record_ring_allocator_unit_tb OK");
        else
            $display("variable_record_ring_allocator_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
rtl/vrra_pkg.sv
rtl/vrra_ctrl.sv
rtl/vrra_dp.sv
rtl/variable_record_ring_allocator_unit.sv
test/variable_record_ring_allocator_unit_tb.sv
